FILE: rtl/ecgqrs_pkg.sv
package ecgqrs_pkg;

  // Ring lengths of the high-pass mean and the energy window.
  localparam int MEAN_LEN   = 7;
  localparam int ENERGY_LEN = 30;
  localparam int RAW_DEPTH  = MEAN_LEN + 1;
  localparam int HP_DEPTH   = ENERGY_LEN + 1;
  localparam int RAW_AW     = $clog2(RAW_DEPTH);
  localparam int HP_AW      = $clog2(HP_DEPTH);

  // Data widths.
  localparam int SAMPLE_W = 16;
  localparam int HP_W     = 18;
  localparam int MSUM_W   = 20;
  localparam int FEAT_W   = 40;
  localparam int LEVEL_W  = 56;
  localparam int PEAK_W   = 41;
  localparam int ACC_W    = 58;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_HOLD_OFF    = 3'd0;
  localparam logic [2:0] REG_WINDOW_LEN  = 3'd1;
  localparam logic [2:0] REG_MEAN_SCALE  = 3'd2;
  localparam logic [2:0] REG_PEAK_WEIGHT = 3'd3;
  localparam logic [2:0] REG_KEEP_WEIGHT = 3'd4;

endpackage

FILE: rtl/ecgqrs_ram.sv
module ecgqrs_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

FILE: rtl/ecg_qrs_detector.sv
// ECG QRS detector.
// Input channel: one signed 16-bit sample per request on ecg_sample_i, taken
// when in_valid_i is high and in_stall_o is low. Output channel: one result
// per sample (beat_found_o, energy_o), delivered when out_valid_o is high
// and out_stall_i is low. Results keep the order of the samples.
// Configuration: APB-style writes to five 16-bit registers at 4*index
// (hold_off, window_len, mean_scale, peak_weight, keep_weight); pready is
// always high and reads return the register value.
// Timing: an accepted sample runs the mean, high-pass, square, energy and
// decision steps, at the end of a threshold window an update step that runs
// five partial products through one 16x21 multiplier, and then the output
// step that loads the result register. The sample rings live in two small
// memories that are read, modified and written back once per sample, so
// one sample is in flight at a time and the next can be taken the cycle
// after the result register is loaded. Reset clears all control state and
// restores the register defaults; ring entries read as zero until written.
// A stalled result holds the result register; the next result waits in the
// output step, with in_stall_o high, until the stalled one has been taken.
module ecg_qrs_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] ecg_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        beat_found_o,
  output logic [39:0] energy_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MEAN = 3'd1;
  localparam logic [2:0] ST_HP   = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_EN   = 3'd4;
  localparam logic [2:0] ST_DEC  = 3'd5;
  localparam logic [2:0] ST_UPD  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam int RA = ecgqrs_pkg::RAW_AW;
  localparam int HA = ecgqrs_pkg::HP_AW;
  localparam int HW = ecgqrs_pkg::HP_W;
  localparam int FW = ecgqrs_pkg::FEAT_W;
  localparam int LW = ecgqrs_pkg::LEVEL_W;
  localparam int PW = ecgqrs_pkg::PEAK_W;
  localparam int AW = ecgqrs_pkg::ACC_W;
  localparam int MW = ecgqrs_pkg::MSUM_W;

  localparam logic signed [PW-1:0] PEAK_MIN = {1'b1, {(PW-1){1'b0}}};
  localparam logic [AW-1:0] LEVEL_MAX = {{(AW-LW){1'b0}}, {LW{1'b1}}};

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [15:0] hold_off_q, window_len_q, mean_scale_q, peak_weight_q, keep_weight_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off_q    <= 16'd20;
      window_len_q  <= 16'd350;
      mean_scale_q  <= 16'd9362;
      peak_weight_q <= 16'd655;
      keep_weight_q <= 16'd62259;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        ecgqrs_pkg::REG_HOLD_OFF:    hold_off_q    <= pwdata[15:0];
        ecgqrs_pkg::REG_WINDOW_LEN:  window_len_q  <= pwdata[15:0];
        ecgqrs_pkg::REG_MEAN_SCALE:  mean_scale_q  <= pwdata[15:0];
        ecgqrs_pkg::REG_PEAK_WEIGHT: peak_weight_q <= pwdata[15:0];
        ecgqrs_pkg::REG_KEEP_WEIGHT: keep_weight_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read mux.
  always_comb begin
    unique case (paddr[4:2])
      ecgqrs_pkg::REG_HOLD_OFF:    prdata = {16'd0, hold_off_q};
      ecgqrs_pkg::REG_WINDOW_LEN:  prdata = {16'd0, window_len_q};
      ecgqrs_pkg::REG_MEAN_SCALE:  prdata = {16'd0, mean_scale_q};
      ecgqrs_pkg::REG_PEAK_WEIGHT: prdata = {16'd0, peak_weight_q};
      ecgqrs_pkg::REG_KEEP_WEIGHT: prdata = {16'd0, keep_weight_q};
      default:                     prdata = 32'd0;
    endcase
  end

  logic accept;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;

  // Ring pointers and derived read addresses.
  logic [RA-1:0] raw_ptr_q, raw_old, raw_dly;
  logic [HA-1:0] hp_ptr_q, hp_old;
  logic [RA:0]   raw_old_w, raw_dly_w;
  logic [HA:0]   hp_old_w;

  always_comb begin
    raw_old_w = {1'b0, raw_ptr_q} + (RA+1)'(1);
    if (raw_old_w >= (RA+1)'(ecgqrs_pkg::RAW_DEPTH)) begin
      raw_old_w = raw_old_w - (RA+1)'(ecgqrs_pkg::RAW_DEPTH);
    end
    raw_dly_w = {1'b0, raw_ptr_q}
              + (RA+1)'(ecgqrs_pkg::RAW_DEPTH - ecgqrs_pkg::RAW_DEPTH / 2);
    if (raw_dly_w >= (RA+1)'(ecgqrs_pkg::RAW_DEPTH)) begin
      raw_dly_w = raw_dly_w - (RA+1)'(ecgqrs_pkg::RAW_DEPTH);
    end
    hp_old_w = {1'b0, hp_ptr_q} + (HA+1)'(1);
    if (hp_old_w >= (HA+1)'(ecgqrs_pkg::HP_DEPTH)) begin
      hp_old_w = hp_old_w - (HA+1)'(ecgqrs_pkg::HP_DEPTH);
    end
  end
  assign raw_old = raw_old_w[RA-1:0];
  assign raw_dly = raw_dly_w[RA-1:0];
  assign hp_old  = hp_old_w[HA-1:0];

  // Sample ring and high-pass ring memories.
  logic [15:0]   raw_rd_old, raw_rd_dly;
  logic [HW-1:0] hp_rd_old, hp_rd_unused;
  logic          hp_we;
  logic signed [HW-1:0] hp_q;

  ecgqrs_ram #(.DEPTH(ecgqrs_pkg::RAW_DEPTH), .WIDTH(16)) u_raw_ram (
    .clk_i     (clk_i),
    .we_i      (accept),
    .waddr_i   (raw_ptr_q),
    .wdata_i   (ecg_sample_i),
    .re_i      (accept),
    .raddr_a_i (raw_old),
    .raddr_b_i (raw_dly),
    .rdata_a_o (raw_rd_old),
    .rdata_b_o (raw_rd_dly)
  );

  ecgqrs_ram #(.DEPTH(ecgqrs_pkg::HP_DEPTH), .WIDTH(HW)) u_hp_ram (
    .clk_i     (clk_i),
    .we_i      (hp_we),
    .waddr_i   (hp_ptr_q),
    .wdata_i   (hp_q),
    .re_i      (accept),
    .raddr_a_i (hp_old),
    .raddr_b_i (hp_old),
    .rdata_a_o (hp_rd_old),
    .rdata_b_o (hp_rd_unused)
  );

  // Written flags stand in for the zero reset of the rings.
  logic [ecgqrs_pkg::RAW_DEPTH-1:0] raw_vld_q;
  logic [ecgqrs_pkg::HP_DEPTH-1:0]  hp_vld_q;
  logic                             old_vld_q, dly_vld_q, hpo_vld_q;

  assign hp_we = (state_q == ST_SQ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_vld_q <= '0;
      hp_vld_q  <= '0;
      old_vld_q <= 1'b0;
      dly_vld_q <= 1'b0;
      hpo_vld_q <= 1'b0;
      raw_ptr_q <= '0;
      hp_ptr_q  <= '0;
    end else begin
      if (accept) begin
        old_vld_q <= raw_vld_q[raw_old];
        dly_vld_q <= raw_vld_q[raw_dly];
        hpo_vld_q <= hp_vld_q[hp_old];
        raw_vld_q[raw_ptr_q] <= 1'b1;
        raw_ptr_q <= raw_old;
      end
      if (hp_we) begin
        hp_vld_q[hp_ptr_q] <= 1'b1;
        hp_ptr_q <= hp_old;
      end
    end
  end

  // Datapath registers of one sample.
  logic signed [15:0]   x_q;
  logic signed [MW-1:0] mean_sum_q, mean_sum_d;
  logic signed [36:0]   mprod_q;
  logic signed [15:0]   dly_q;
  logic signed [HW-1:0] o_q;
  logic [34:0]          osq_q, hsq_q;
  logic [FW-1:0]        esum_q;
  logic [15:0]          warm_q;

  logic signed [15:0]   old_s, dly_s;
  logic signed [20:0]   m_val;
  logic signed [22:0]   hp_full;
  logic signed [HW-1:0] hp_d;
  logic signed [35:0]   osq_full, hsq_full;

  assign old_s = old_vld_q ? $signed(raw_rd_old) : 16'sd0;
  assign dly_s = dly_vld_q ? $signed(raw_rd_dly) : 16'sd0;
  assign mean_sum_d = mean_sum_q + MW'(x_q) - MW'(old_s);
  assign m_val = 21'(($signed(mprod_q) + 37'sd32768) >>> 16);
  assign hp_full = 23'(dly_q) - 23'(m_val);
  assign osq_full = o_q * o_q;
  assign hsq_full = hp_q * hp_q;

  // High-pass clamp, zero during the mean warm-up.
  always_comb begin
    if (warm_q < 16'(ecgqrs_pkg::MEAN_LEN)) begin
      hp_d = '0;
    end else if (hp_full > 23'sd131071) begin
      hp_d = 18'sd131071;
    end else if (hp_full < -23'sd131072) begin
      hp_d = -18'sd131072;
    end else begin
      hp_d = hp_full[HW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= $signed(ecg_sample_i);
    end
    if (state_q == ST_MEAN) begin
      mprod_q <= $signed({1'b0, mean_scale_q}) * mean_sum_d;
      dly_q   <= dly_s;
      o_q     <= hpo_vld_q ? $signed(hp_rd_old) : '0;
    end
    if (state_q == ST_HP) begin
      hp_q  <= hp_d;
      osq_q <= osq_full[34:0];
    end
    if (state_q == ST_SQ) begin
      hsq_q <= hsq_full[34:0];
    end
  end

  // Threshold and hold-off state.
  logic [LW-1:0]        level_q;
  logic signed [PW-1:0] peak_q;
  logic [15:0]          wcnt_q, hcnt_q;
  logic                 holding_q;
  logic                 beat_q;
  logic [FW-1:0]        feat_q;

  logic [FW-1:0]        feature;
  logic [LW-1:0]        fq, lvl1;
  logic [15:0]          hcnt_inc;
  logic                 hold_n, hold_clr, beat_d, win_end;
  logic signed [PW-1:0] peak_n;

  assign feature  = (warm_q >= 16'(ecgqrs_pkg::ENERGY_LEN)) ? esum_q : '0;
  assign fq       = {feature, 16'd0};
  assign lvl1     = (warm_q < window_len_q && fq > level_q) ? fq : level_q;
  assign hcnt_inc = (hcnt_q != 16'hFFFF) ? hcnt_q + 16'd1 : hcnt_q;
  assign hold_clr = holding_q && hcnt_inc >= hold_off_q && fq <= lvl1;
  assign hold_n   = holding_q & ~hold_clr;
  assign peak_n   = ($signed({1'b0, feature}) > peak_q) ? $signed({1'b0, feature}) : peak_q;
  assign beat_d   = (fq > lvl1) && !hold_n;
  assign win_end  = !beat_d && (wcnt_q >= window_len_q);

  // Threshold update sequencer: five partial products through one multiplier.
  logic [2:0]    step_q;
  logic [15:0]   mul_a;
  logic [20:0]   mul_b;
  logic [36:0]   uprod_q;
  logic [AW-1:0] acc_q;
  logic [PW-1:0] pk;

  assign pk = peak_q[PW-1] ? '0 : peak_q;

  always_comb begin
    case (step_q)
      3'd0:    begin mul_a = keep_weight_q; mul_b = {5'd0, level_q[15:0]}; end
      3'd1:    begin mul_a = keep_weight_q; mul_b = {1'b0, level_q[35:16]}; end
      3'd2:    begin mul_a = keep_weight_q; mul_b = {1'b0, level_q[55:36]}; end
      3'd3:    begin mul_a = peak_weight_q; mul_b = {1'b0, pk[19:0]}; end
      default: begin mul_a = peak_weight_q; mul_b = pk[40:20]; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD) begin
      uprod_q <= mul_a * mul_b;
      case (step_q)
        3'd1:    acc_q <= (AW'(uprod_q) + AW'(32768)) >> 16;
        3'd2:    acc_q <= acc_q + AW'(uprod_q);
        3'd3:    acc_q <= acc_q + (AW'(uprod_q) << 20);
        3'd4:    acc_q <= acc_q + AW'(uprod_q);
        3'd5:    acc_q <= acc_q + (AW'(uprod_q) << 20);
        default: ;
      endcase
    end
  end

  // Sequencer and state commits.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_MEAN;
      ST_MEAN: state_d = ST_HP;
      ST_HP:   state_d = ST_SQ;
      ST_SQ:   state_d = ST_EN;
      ST_EN:   state_d = ST_DEC;
      ST_DEC:  state_d = win_end ? ST_UPD : ST_OUT;
      ST_UPD:  if (step_q == 3'd6) state_d = ST_OUT;
      ST_OUT:  if (!out_valid_o || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mean_sum_q  <= '0;
      esum_q      <= '0;
      warm_q      <= '0;
      level_q     <= '0;
      peak_q      <= PEAK_MIN;
      wcnt_q      <= '0;
      hcnt_q      <= '0;
      holding_q   <= 1'b0;
      step_q      <= '0;
      beat_q      <= 1'b0;
      feat_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_MEAN: mean_sum_q <= mean_sum_d;
        ST_EN:   esum_q <= esum_q + FW'(hsq_q) - FW'(osq_q);
        ST_DEC: begin
          level_q   <= lvl1;
          peak_q    <= peak_n;
          feat_q    <= feature;
          beat_q    <= beat_d;
          step_q    <= '0;
          warm_q    <= (warm_q != 16'hFFFF) ? warm_q + 16'd1 : warm_q;
          if (holding_q) begin
            hcnt_q <= hold_clr ? 16'd0 : hcnt_inc;
          end
          holding_q <= hold_n | beat_d;
          if (!beat_d) begin
            wcnt_q <= win_end ? 16'd0 : wcnt_q + 16'd1;
          end
        end
        ST_UPD: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd6) begin
            level_q <= (acc_q > LEVEL_MAX) ? LEVEL_MAX[LW-1:0] : acc_q[LW-1:0];
            peak_q  <= PEAK_MIN;
          end
        end
        ST_OUT: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!out_valid_o || !out_stall_i)) begin
      beat_found_o <= beat_q;
      energy_o     <= feat_q;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_MEAN)
    else $error("accepted sample did not start the sequence");
  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside the output state");
  a_energy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esum_q[FW-1] == 1'b0)
    else $error("energy sum out of range");
  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q[PW-1] == 1'b0 || peak_q == PEAK_MIN)
    else $error("window peak holds a negative value other than the minimum");
  a_update_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD && $past(state_q) == ST_DEC |-> wcnt_q == 16'd0)
    else $error("threshold update without window restart");
`endif

endmodule

FILE: verif/ecg_qrs_detector_tb.sv
module ecg_qrs_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned FEAT_MAX  = 64'hFF_FFFF_FFFF;
  localparam longint unsigned LEVEL_MAX = 64'hFF_FFFF_FFFF_FFFF;
  localparam longint PEAK_FLOOR = -64'sd1099511627776;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAW_DEPTH = ecgqrs_pkg::RAW_DEPTH;
  localparam int HP_DEPTH  = ecgqrs_pkg::HP_DEPTH;

  typedef struct packed {
    logic        beat;
    logic [39:0] energy;
  } beat_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] ecg_sample_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        beat_found_o;
  logic [39:0] energy_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ecg_qrs_detector u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Mirror of the detector state.
  int unsigned cfg_hold_off, cfg_window_len, cfg_mean_scale, cfg_peak_wt, cfg_keep_wt;
  int          raw_hist [RAW_DEPTH];
  longint      hp_hist [HP_DEPTH];
  int unsigned raw_idx, hp_idx, warm_cnt, win_cnt, hold_cnt;
  longint      mean_acc, win_peak;
  longint unsigned energy_acc, thresh;
  bit          in_hold;

  logic [15:0]  sample_queue [$];
  beat_result_t expected_beats [$];
  int  sender_idle_pct = 0, stall_pct = 0;
  bit  long_stall = 0, sender_hold = 0;
  int  errors = 0;
  int  cycles = 0;

  function automatic longint floor_q16(longint v);
    return v >>> 16;
  endfunction

  task automatic reset_model();
    cfg_hold_off = 20; cfg_window_len = 350; cfg_mean_scale = 9362;
    cfg_peak_wt = 655; cfg_keep_wt = 62259;
    foreach (raw_hist[i]) raw_hist[i] = 0;
    foreach (hp_hist[i]) hp_hist[i] = 0;
    raw_idx = 0; hp_idx = 0; mean_acc = 0; energy_acc = 0; warm_cnt = 0;
    thresh = 0; win_peak = PEAK_FLOOR; win_cnt = 0; in_hold = 0; hold_cnt = 0;
  endtask

  // Computes the detector result for one sample and advances the mirror.
  function automatic beat_result_t detect_step(logic [15:0] s);
    beat_result_t r;
    int x, old_slot;
    longint hp, m, o;
    longint unsigned feat, fq, pk, keep, nl;
    bit fire, wend;
    x = int'($signed(s));
    hp = 0;
    fire = 0;
    raw_hist[raw_idx] = x;
    mean_acc += longint'(x) - longint'(raw_hist[(raw_idx + 1) % RAW_DEPTH]);
    if (warm_cnt >= ecgqrs_pkg::MEAN_LEN) begin
      m = floor_q16(longint'(cfg_mean_scale) * mean_acc + 32768);
      hp = longint'(raw_hist[(raw_idx + RAW_DEPTH - RAW_DEPTH / 2) % RAW_DEPTH]) - m;
      if (hp > 131071) hp = 131071;
      if (hp < -131072) hp = -131072;
    end
    raw_idx = (raw_idx + 1) % RAW_DEPTH;
    old_slot = (hp_idx + 1) % HP_DEPTH;
    o = hp_hist[old_slot];
    hp_hist[hp_idx] = hp;
    energy_acc = energy_acc + longint'(hp * hp) - longint'(o * o);
    hp_idx = (hp_idx + 1) % HP_DEPTH;
    feat = 0;
    if (warm_cnt >= ecgqrs_pkg::ENERGY_LEN) begin
      feat = (energy_acc > FEAT_MAX) ? FEAT_MAX : energy_acc;
    end
    fq = feat << 16;
    if (warm_cnt < cfg_window_len && fq > thresh) thresh = fq;
    if (warm_cnt < 65535) warm_cnt++;
    // Hold-off release.
    if (in_hold) begin
      if (hold_cnt < 65535) hold_cnt++;
      if (hold_cnt >= cfg_hold_off && fq <= thresh) begin
        in_hold = 0;
        hold_cnt = 0;
      end
    end
    if (longint'(feat) > win_peak) win_peak = longint'(feat);
    if (fq > thresh && !in_hold) begin
      in_hold = 1;
      fire = 1;
    end else begin
      // Window end threshold decay.
      wend = win_cnt >= cfg_window_len;
      win_cnt++;
      if (wend) begin
        pk = (win_peak < 0) ? 0 : longint'(win_peak);
        keep = longint'(cfg_keep_wt) * (thresh >> 16)
             + ((longint'(cfg_keep_wt) * (thresh & 16'hFFFF) + 32768) >> 16);
        nl = longint'(cfg_peak_wt) * pk + keep;
        thresh = (nl > LEVEL_MAX) ? LEVEL_MAX : nl;
        win_cnt = 0;
        win_peak = PEAK_FLOOR;
      end
    end
    r.beat = fire;
    r.energy = feat[39:0];
    return r;
  endfunction

  // Sample driver.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) expected_beats.push_back(detect_step(ecg_sample_i));
        if (sample_queue.size() > 0 && !sender_hold &&
            $urandom_range(99) >= sender_idle_pct) begin
          in_valid_i <= 1'b1;
          ecg_sample_i <= sample_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk_i) begin
    beat_result_t want;
    cycles++;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat_found=%0d energy=%0d", beat_found_o, energy_o);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          if (beat_found_o !== want.beat) begin
            $error("beat_found expected %0d actual %0d", want.beat, beat_found_o);
            errors++;
          end
          if (energy_o !== want.energy) begin
            $error("energy expected %0d actual %0d", want.energy, energy_o);
            errors++;
          end
        end
      end
      out_stall_i <= long_stall || ($urandom_range(99) < stall_pct);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {16'($urandom_range(65535)), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      ecgqrs_pkg::REG_HOLD_OFF:    cfg_hold_off = val;
      ecgqrs_pkg::REG_WINDOW_LEN:  cfg_window_len = val;
      ecgqrs_pkg::REG_MEAN_SCALE:  cfg_mean_scale = val;
      ecgqrs_pkg::REG_PEAK_WEIGHT: cfg_peak_wt = val;
      ecgqrs_pkg::REG_KEEP_WEIGHT: cfg_keep_wt = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sample_queue.size() > 0 || in_valid_i || expected_beats.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Bursty ECG-like content: baseline noise with occasional spikes.
  task automatic push_random(int count);
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0: sample_queue.push_back(16'($urandom));
        1, 2: sample_queue.push_back(16'($signed($urandom_range(24000)) - 4000));
        default: sample_queue.push_back(16'($signed($urandom_range(600)) - 300));
      endcase
    end
  endtask

  initial begin
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: field extremes at reset defaults, short window settings.
    apb_write(ecgqrs_pkg::REG_WINDOW_LEN, 16'd1);
    apb_write(ecgqrs_pkg::REG_HOLD_OFF, 16'd0);
    sample_queue.push_back(16'h7FFF); sample_queue.push_back(16'h8000);
    sample_queue.push_back(16'h0000); sample_queue.push_back(16'hFFFF);
    repeat (4) begin
      sample_queue.push_back(16'h7FFF); sample_queue.push_back(16'h8000);
    end
    repeat (12) sample_queue.push_back(16'h0001);
    drain();

    // Phase 1: reset-like weights, no idling.
    apb_write(ecgqrs_pkg::REG_WINDOW_LEN, 16'd40);
    apb_write(ecgqrs_pkg::REG_HOLD_OFF, 16'd5);
    apb_write(ecgqrs_pkg::REG_MEAN_SCALE, 16'd9362);
    apb_write(ecgqrs_pkg::REG_PEAK_WEIGHT, 16'd655);
    apb_write(ecgqrs_pkg::REG_KEEP_WEIGHT, 16'd62259);
    push_random(300);
    drain();

    // Phase 2: extreme weights, sender idling.
    sender_idle_pct = 55;
    apb_write(ecgqrs_pkg::REG_MEAN_SCALE, 16'hFFFF);
    apb_write(ecgqrs_pkg::REG_PEAK_WEIGHT, 16'hFFFF);
    apb_write(ecgqrs_pkg::REG_KEEP_WEIGHT, 16'hFFFF);
    apb_write(ecgqrs_pkg::REG_HOLD_OFF, 16'hFFFF);
    apb_write(ecgqrs_pkg::REG_WINDOW_LEN, 16'd0);
    push_random(300);
    drain();

    // Phase 3: zero weights, receiver stalling, with a long full-stall stretch.
    sender_idle_pct = 0; stall_pct = 55;
    apb_write(ecgqrs_pkg::REG_MEAN_SCALE, 16'd0);
    apb_write(ecgqrs_pkg::REG_PEAK_WEIGHT, 16'd0);
    apb_write(ecgqrs_pkg::REG_KEEP_WEIGHT, 16'd0);
    apb_write(ecgqrs_pkg::REG_HOLD_OFF, 16'd3);
    apb_write(ecgqrs_pkg::REG_WINDOW_LEN, 16'hFFFF);
    push_random(300);
    long_stall = 1;
    repeat (400) @(posedge clk_i);
    long_stall = 0;
    drain();

    // Phase 4: random settings, both sides idling, one full pause midway.
    sender_idle_pct = 21; stall_pct = 21;
    apb_write(ecgqrs_pkg::REG_MEAN_SCALE, 16'($urandom));
    apb_write(ecgqrs_pkg::REG_PEAK_WEIGHT, 16'($urandom_range(2000)));
    apb_write(ecgqrs_pkg::REG_KEEP_WEIGHT, 16'($urandom_range(65535, 50000)));
    apb_write(ecgqrs_pkg::REG_HOLD_OFF, 16'($urandom_range(30)));
    apb_write(ecgqrs_pkg::REG_WINDOW_LEN, 16'($urandom_range(60, 2)));
    push_random(150);
    while (sample_queue.size() > 0) @(posedge clk_i);
    sender_hold = 1;
    while (in_valid_i || expected_beats.size() > 0) @(posedge clk_i);
    sender_hold = 0;
    push_random(150);
    drain();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
